/* src/at2_pkg.sv */
// Shared types, widths and arctangent tables for the atan2 pipeline.
`timescale 1ns / 1ps

package at2_pkg;

    localparam int SAMPLE_W   = 16;  // input sample width
    localparam int MAG_W      = 15;  // saturated magnitude width
    localparam int Q_W        = 15;  // Q15 ratio width, 0..32767
    localparam int IDX_W      = 4;   // table segment index
    localparam int FRAC_W     = 11;  // interpolation fraction
    localparam int BASE_W     = 16;  // table angle, up to 45000
    localparam int DELTA_W    = 12;  // segment slope, up to 3576
    localparam int PROD_W     = DELTA_W + FRAC_W;
    localparam int ANG_W      = 19;  // output angle
    localparam int DIV_STAGES = Q_W; // one quotient bit per stage

    localparam logic [Q_W-1:0] RATIO_MAX = {Q_W{1'b1}};

    localparam logic signed [ANG_W-1:0] ANG_ZERO    = 19'sd0;
    localparam logic signed [ANG_W-1:0] ANG_HALF    = 19'sd180000;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = 19'sd90000;
    localparam logic [16:0]             MIRROR_90   = 17'd90000;

    // atan(k/16) in millidegrees for segment starts k = 0..15
    localparam logic [BASE_W-1:0] ATAN_BASE [16] = '{
        16'd0,     16'd3576,  16'd7125,  16'd10620,
        16'd14036, 16'd17354, 16'd20556, 16'd23629,
        16'd26565, 16'd29358, 16'd32005, 16'd34509,
        16'd36870, 16'd39090, 16'd41186, 16'd43152
    };

    // atan((k+1)/16) - atan(k/16); last segment ends at 45000
    localparam logic [DELTA_W-1:0] ATAN_DELTA [16] = '{
        12'd3576, 12'd3549, 12'd3495, 12'd3416,
        12'd3318, 12'd3202, 12'd3073, 12'd2936,
        12'd2793, 12'd2647, 12'd2504, 12'd2361,
        12'd2220, 12'd2096, 12'd1966, 12'd1848
    };

    // Per-item sideband that rides alongside the divider
    typedef struct packed {
        logic                     special;     // axis case, angle already known
        logic signed [ANG_W-1:0]  special_val;
        logic                     swap;        // |y| > |x|, mirror about 45 deg
        logic                     eq;          // equal magnitudes, ratio saturates
        logic                     x_neg;
        logic                     y_neg;
    } side_t;

endpackage

/* src/atan2_millidegree_table_interp.sv */
// Top level: four-quadrant atan2 in millidegrees with output skid buffer.
`timescale 1ns / 1ps
//
// Usage
//   Input channel: in_valid / in_stall carry a (y_value, x_value) pair of
//   signed 16-bit samples; a transfer happens on a rising edge with in_valid
//   high and in_stall low. Output channel: out_valid / out_stall carry
//   angle_mdeg, a signed 19-bit angle in millidegrees, -180000..180000.
//   Throughput: one transfer per cycle on each side, sustained while neither side stalls.
//   Stages from input transfer to out_valid:
//   1 front stage, 15 divider stages (one quotient bit each, the long pole),
//   2 lookup/interpolation stages, 1 output register.
//   All pipeline stages advance together; valid bits travel with the data.
//   When the receiver stalls, a result already in the output register holds
//   and the next one lands in a one-entry skid register; only once the skid
//   register is full does the pipeline freeze and in_stall rise. in_stall
//   comes straight from a flop, so it never depends on out_stall in the same
//   cycle. Nothing is dropped or duplicated across a stall.
//   Reset (rst_n low, asynchronous) clears every valid bit; the block is
//   ready for input in the first cycle after reset. No configuration.
//
module atan2_millidegree_table_interp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [at2_pkg::SAMPLE_W-1:0] y_value,
    input  logic signed [at2_pkg::SAMPLE_W-1:0] x_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [at2_pkg::ANG_W-1:0]    angle_mdeg
);
    import at2_pkg::*;

    // pipeline runs whenever the skid register is free
    logic en;

    logic              prep_valid;
    logic [MAG_W-1:0]  prep_num;
    logic [MAG_W-1:0]  prep_den;
    side_t             prep_side;

    logic              div_valid;
    logic [Q_W-1:0]    div_ratio;
    side_t             div_side;

    logic              pipe_valid;
    logic signed [ANG_W-1:0] pipe_angle;

    // output register plus one skid entry
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [ANG_W-1:0] out_data_reg;
    logic signed [ANG_W-1:0] out_data_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic signed [ANG_W-1:0] skid_data_reg;
    logic signed [ANG_W-1:0] skid_data_next;
    logic                    out_take;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    at2_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .y_value   (y_value),
        .x_value   (x_value),
        .valid_reg (prep_valid),
        .num_reg   (prep_num),
        .den_reg   (prep_den),
        .side_reg  (prep_side)
    );

    at2_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .num       (prep_num),
        .den       (prep_den),
        .side_in   (prep_side),
        .out_valid (div_valid),
        .ratio     (div_ratio),
        .side_out  (div_side)
    );

    at2_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .ratio     (div_ratio),
        .side_in   (div_side),
        .out_valid (pipe_valid),
        .angle     (pipe_angle)
    );

    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (en)
        begin
            // last pipeline stage hands its item over on this edge
            if (pipe_valid)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pipe_angle;
                end
                else
                begin
                    skid_valid_next = 1'b1;
                    skid_data_next  = pipe_angle;
                end
            end
            else if (out_take)
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (out_take)
        begin
            // drain skid into the output register
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign angle_mdeg = out_data_reg;

    // skid entry only ever backs up a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with empty output register");

    // skid fills only when the output was stalled
    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid register filled without a stall");

    // delivered angle stays within half a turn
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (angle_mdeg >= -ANG_HALF) && (angle_mdeg <= ANG_HALF))
        else $error("angle out of range");

endmodule

/* src/at2_prep.sv */
// Front stage: axis cases, saturated magnitudes, operand ordering.
`timescale 1ns / 1ps

module at2_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [at2_pkg::SAMPLE_W-1:0] y_value,
    input  logic signed [at2_pkg::SAMPLE_W-1:0] x_value,
    output logic                           valid_reg,
    output logic [at2_pkg::MAG_W-1:0]      num_reg,
    output logic [at2_pkg::MAG_W-1:0]      den_reg,
    output at2_pkg::side_t                 side_reg
);
    import at2_pkg::*;

    logic [SAMPLE_W-1:0] ay_full;
    logic [SAMPLE_W-1:0] ax_full;
    logic [MAG_W-1:0]    ay;
    logic [MAG_W-1:0]    ax;
    logic [MAG_W-1:0]    num_next;
    logic [MAG_W-1:0]    den_next;
    side_t               side_next;

    always_comb
    begin
        ay_full = y_value[SAMPLE_W-1] ? SAMPLE_W'(-y_value) : SAMPLE_W'(y_value);
        ax_full = x_value[SAMPLE_W-1] ? SAMPLE_W'(-x_value) : SAMPLE_W'(x_value);
        // only -32768 sets the top bit here
        ay = ay_full[SAMPLE_W-1] ? {MAG_W{1'b1}} : ay_full[MAG_W-1:0];
        ax = ax_full[SAMPLE_W-1] ? {MAG_W{1'b1}} : ax_full[MAG_W-1:0];

        side_next.swap  = (ay > ax);
        side_next.eq    = (ay == ax);
        side_next.x_neg = x_value[SAMPLE_W-1];
        side_next.y_neg = y_value[SAMPLE_W-1];
        num_next = side_next.swap ? ax : ay;
        den_next = side_next.swap ? ay : ax;
        // equal magnitudes: keep the divider's remainder below the divisor
        if (side_next.eq)
        begin
            num_next = '0;
        end

        side_next.special     = 1'b0;
        side_next.special_val = ANG_ZERO;
        if (y_value == '0)
        begin
            side_next.special     = 1'b1;
            side_next.special_val = x_value[SAMPLE_W-1] ? ANG_HALF : ANG_ZERO;
        end
        else if (x_value == '0)
        begin
            side_next.special     = 1'b1;
            side_next.special_val = y_value[SAMPLE_W-1] ? -ANG_QUARTER : ANG_QUARTER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

endmodule

/* src/at2_div.sv */
// Pipelined restoring divider: Q15 ratio num/den, one quotient bit per stage.
`timescale 1ns / 1ps

module at2_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [at2_pkg::MAG_W-1:0] num,
    input  logic [at2_pkg::MAG_W-1:0] den,
    input  at2_pkg::side_t            side_in,
    output logic                      out_valid,
    output logic [at2_pkg::Q_W-1:0]   ratio,
    output at2_pkg::side_t            side_out
);
    import at2_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [MAG_W-1:0]      rem_reg  [DIV_STAGES];
    logic [MAG_W-1:0]      den_reg  [DIV_STAGES];
    logic [Q_W-1:0]        q_reg    [DIV_STAGES];
    side_t                 side_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic             v_in;
        logic [MAG_W-1:0] rem_in;
        logic [MAG_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        side_t            side_i;
        logic [MAG_W:0]   rem2;
        logic             ge;
        logic [MAG_W-1:0] rem_next;
        logic [Q_W-1:0]   q_next;

        if (s == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign side_i = side_in;
        end
        else
        begin : g_rest
            assign v_in   = valid_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign side_i = side_reg[s-1];
        end

        always_comb
        begin
            rem2     = {rem_in, 1'b0};
            ge       = (rem2 >= {1'b0, den_in});
            rem_next = ge ? MAG_W'(rem2 - {1'b0, den_in}) : rem2[MAG_W-1:0];
            q_next   = {q_in[Q_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in;
                q_reg[s]    <= q_next;
                side_reg[s] <= side_i;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];
    // final remainder is unused; equal magnitudes saturate
    assign ratio     = side_reg[DIV_STAGES-1].eq ? RATIO_MAX : q_reg[DIV_STAGES-1];

endmodule

/* src/at2_interp.sv */
// Table lookup and slope multiply, then mirror and quadrant restore.
`timescale 1ns / 1ps

module at2_interp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [at2_pkg::Q_W-1:0]           ratio,
    input  at2_pkg::side_t                    side_in,
    output logic                              out_valid,
    output logic signed [at2_pkg::ANG_W-1:0]  angle
);
    import at2_pkg::*;

    // stage 1: lookup and multiply
    logic                v1_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [PROD_W-1:0]   prod_reg;
    side_t               side1_reg;

    logic [IDX_W-1:0]    idx;
    logic [FRAC_W-1:0]   frac;
    logic [PROD_W-1:0]   prod_next;

    // stage 2: finish
    logic                v2_reg;
    logic signed [ANG_W-1:0] angle_reg;

    logic [BASE_W-1:0]   ang16;
    logic [16:0]         ang17;
    logic signed [ANG_W-1:0] pos;
    logic signed [ANG_W-1:0] angle_next;

    always_comb
    begin
        idx       = ratio[Q_W-1 -: IDX_W];
        frac      = ratio[FRAC_W-1:0];
        prod_next = PROD_W'(ATAN_DELTA[idx]) * PROD_W'(frac);
    end

    always_comb
    begin
        ang16 = base_reg + BASE_W'(prod_reg >> FRAC_W);
        ang17 = side1_reg.swap ? (MIRROR_90 - {1'b0, ang16}) : {1'b0, ang16};
        pos   = side1_reg.x_neg ? (ANG_HALF - $signed({2'b00, ang17}))
                                : $signed({2'b00, ang17});
        angle_next = side1_reg.y_neg ? -pos : pos;
        if (side1_reg.special)
        begin
            angle_next = side1_reg.special_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg  <= ATAN_BASE[idx];
            prod_reg  <= prod_next;
            side1_reg <= side_in;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = v2_reg;
    assign angle     = angle_reg;

endmodule
